[src/srbp_pkg.sv]
// Shared types, constants and helpers of the sensor record bitstream parser.
`timescale 1ns / 1ps
`default_nettype none

package srbp_pkg;

	// Default record geometry.
	localparam int SENSOR_COUNT_DEF = 5;
	localparam int VALUE_BITS_DEF   = 16;

	// Fixed field widths.
	localparam int LEN_BITS       = 6;
	localparam int CODE_BITS      = 2;
	localparam int TIME_W         = 64;
	localparam int STATUS_W       = 10;
	localparam int COUNT_W        = 3;
	localparam int INDEX_W        = 3;
	// This covers a sensor count of up to fifteen.
	localparam int SENSORS_LEFT_W = 4;

	// Result queue geometry.
	localparam int OQ_DEPTH = 3;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 2;

	typedef enum logic [2:0] {
		PH_LEN    = 3'd0,
		PH_DELTA  = 3'd1,
		PH_STATUS = 3'd2,
		PH_VALUES = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_TIME   = 2'd0,
		KIND_STATUS = 2'd1,
		KIND_VALUE  = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} in_t;

	typedef struct packed {
		kind_t                kind;
		logic [TIME_W-1:0]    value;
		logic [STATUS_W-1:0]  status_codes;
		logic [COUNT_W-1:0]   present_count;
		logic [INDEX_W-1:0]   value_index;
		logic                 last;
	} res_t;

	typedef struct packed {
		phase_t                    phase;
		logic [5:0]                bits_in_field;
		logic [TIME_W-1:0]         field_shift;
		logic [LEN_BITS-1:0]       delta_length;
		logic [TIME_W-1:0]         time_total;
		logic [SENSORS_LEFT_W-1:0] sensors_left;
		logic [INDEX_W-1:0]        value_ordinal;
	} parse_state_t;

	localparam parse_state_t PARSE_STATE_RST = '{
		phase:         PH_LEN,
		bits_in_field: '0,
		field_shift:   '0,
		delta_length:  '0,
		time_total:    '0,
		sensors_left:  '0,
		value_ordinal: '0
	};

	function automatic res_t mk_res(kind_t k, logic [TIME_W-1:0] v,
			logic [STATUS_W-1:0] codes, logic [COUNT_W-1:0] cnt,
			logic [INDEX_W-1:0] idx);
		res_t r;
		r.kind          = k;
		r.value         = v;
		r.status_codes  = codes;
		r.present_count = cnt;
		r.value_index   = idx;
		r.last          = 1'b0;
		return r;
	endfunction

	function automatic logic [OQ_PTR_W-1:0] oq_next(logic [OQ_PTR_W-1:0] p);
		logic [OQ_PTR_W-1:0] n;
		if (p == OQ_PTR_W'(OQ_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + OQ_PTR_W'(1);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[src/srbp_parse.sv]
// Combinational byte parser: eight bit steps from the current state to the next.
`timescale 1ns / 1ps
`default_nettype none

module srbp_parse #(
	parameter int SENSOR_COUNT = srbp_pkg::SENSOR_COUNT_DEF,
	parameter int VALUE_BITS   = srbp_pkg::VALUE_BITS_DEF
) (
	input  srbp_pkg::parse_state_t cur,
	input  srbp_pkg::in_t          data_in,
	output srbp_pkg::parse_state_t nxt,
	output srbp_pkg::res_t         res0,
	output srbp_pkg::res_t         res1,
	output logic [1:0]             res_n
);

	localparam int STATUS_BITS = srbp_pkg::CODE_BITS * SENSOR_COUNT;

	always_comb begin
		srbp_pkg::parse_state_t st;
		srbp_pkg::res_t         r0;
		srbp_pkg::res_t         r1;
		srbp_pkg::res_t         tmp;
		logic [1:0]                      n;
		logic                            emit;
		logic [srbp_pkg::TIME_W-1:0]     tdelta;
		logic                            tdone;
		logic                            tslot_ok;
		logic                            tslot;
		logic [srbp_pkg::TIME_W-1:0]     tsum;
		logic [srbp_pkg::LEN_BITS-1:0]   len;
		logic [srbp_pkg::SENSORS_LEFT_W-1:0] cnt;

		st       = cur;
		r0       = '0;
		r1       = '0;
		tmp      = '0;
		n        = 2'd0;
		emit     = 1'b0;
		tdelta   = '0;
		tdone    = 1'b0;
		tslot_ok = 1'b0;
		tslot    = 1'b0;
		len      = '0;
		cnt      = '0;

		if (data_in.stream_start) begin
			st = srbp_pkg::PARSE_STATE_RST;
		end

		for (int b = 7; b >= 0; b--) begin
			emit = 1'b0;
			if (st.phase != srbp_pkg::PH_DONE) begin
				st.field_shift   = {st.field_shift[srbp_pkg::TIME_W-2:0], data_in.data_byte[b]};
				st.bits_in_field = st.bits_in_field + 6'd1;
				case (st.phase)
					srbp_pkg::PH_LEN: begin
						if (st.bits_in_field >= 6'(srbp_pkg::LEN_BITS)) begin
							len              = st.field_shift[srbp_pkg::LEN_BITS-1:0];
							st.field_shift   = '0;
							st.bits_in_field = '0;
							if (len == '0) begin
								emit     = 1'b1;
								tmp      = srbp_pkg::mk_res(srbp_pkg::KIND_END, '0, '0, '0, '0);
								st.phase = srbp_pkg::PH_DONE;
							end else begin
								st.delta_length = len;
								st.phase        = srbp_pkg::PH_DELTA;
							end
						end
					end
					srbp_pkg::PH_DELTA: begin
						if (st.bits_in_field >= st.delta_length) begin
							// The sum is formed once after the bit steps; only the slot is noted here.
							tdelta           = st.field_shift;
							tdone            = 1'b1;
							tslot_ok         = (n != 2'd2);
							tslot            = n[0];
							st.field_shift   = '0;
							st.bits_in_field = '0;
							emit             = 1'b1;
							tmp = srbp_pkg::mk_res(srbp_pkg::KIND_TIME, '0, '0, '0, '0);
							st.phase         = srbp_pkg::PH_STATUS;
						end
					end
					srbp_pkg::PH_STATUS: begin
						if (st.bits_in_field >= 6'(STATUS_BITS)) begin
							cnt = '0;
							for (int s = 0; s < SENSOR_COUNT; s++) begin
								if (st.field_shift[srbp_pkg::CODE_BITS*(SENSOR_COUNT-1-s) +:
										srbp_pkg::CODE_BITS] < 2'd2) begin
									cnt = cnt + srbp_pkg::SENSORS_LEFT_W'(1);
								end
							end
							emit = 1'b1;
							tmp  = srbp_pkg::mk_res(srbp_pkg::KIND_STATUS, '0,
								st.field_shift[srbp_pkg::STATUS_W-1:0],
								cnt[srbp_pkg::COUNT_W-1:0], '0);
							st.field_shift   = '0;
							st.bits_in_field = '0;
							if (cnt == '0) begin
								st.phase = srbp_pkg::PH_LEN;
							end else begin
								st.sensors_left  = cnt;
								st.value_ordinal = '0;
								st.phase         = srbp_pkg::PH_VALUES;
							end
						end
					end
					srbp_pkg::PH_VALUES: begin
						if (st.bits_in_field >= 6'(VALUE_BITS)) begin
							emit = 1'b1;
							tmp  = srbp_pkg::mk_res(srbp_pkg::KIND_VALUE, st.field_shift, '0, '0,
								st.value_ordinal);
							st.field_shift   = '0;
							st.bits_in_field = '0;
							st.value_ordinal = st.value_ordinal + srbp_pkg::INDEX_W'(1);
							if (st.sensors_left != '0) begin
								st.sensors_left = st.sensors_left - srbp_pkg::SENSORS_LEFT_W'(1);
							end
							if (st.sensors_left == '0) begin
								st.phase = srbp_pkg::PH_LEN;
							end
						end
					end
					default: begin
						st.phase = srbp_pkg::PH_DONE;
					end
				endcase
			end
			// Completions beyond the second in one byte are dropped.
			if (emit) begin
				if (n == 2'd0) begin
					r0 = tmp;
				end else if (n == 2'd1) begin
					r1 = tmp;
				end
				if (n != 2'd2) begin
					n = n + 2'd1;
				end
			end
		end

		// A status field and a six-bit length field lie between two deltas, so at most one time delta ends per byte.
		tsum = st.time_total + tdelta;
		if (tdone) begin
			st.time_total = tsum;
			if (tslot_ok) begin
				if (tslot) begin
					r1.value = tsum;
				end else begin
					r0.value = tsum;
				end
			end
		end

		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end

		nxt   = st;
		res0  = r0;
		res1  = r1;
		res_n = n;
	end

endmodule

`default_nettype wire

[src/srbp_outq.sv]
// Three-entry result queue that takes up to two results per cycle and returns one while rec_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module srbp_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     push_n,
	input  srbp_pkg::res_t push0,
	input  srbp_pkg::res_t push1,
	output logic           full_ish,
	output logic           rec_valid,
	input  logic           rec_stall,
	output srbp_pkg::res_t rec_data
);

	srbp_pkg::res_t                  mem_q [srbp_pkg::OQ_DEPTH];
	logic [srbp_pkg::OQ_PTR_W-1:0]   wr_q;
	logic [srbp_pkg::OQ_PTR_W-1:0]   rd_q;
	logic [srbp_pkg::OQ_CNT_W-1:0]   count_q;
	logic [srbp_pkg::OQ_PTR_W-1:0]   wr_nx1;
	logic                            pop;

	assign wr_nx1    = srbp_pkg::oq_next(wr_q);
	assign pop       = rec_valid && !rec_stall;
	assign rec_valid = (count_q != '0);
	assign rec_data  = mem_q[rd_q];
	// Two free entries are needed before a byte can be taken.
	assign full_ish  = (count_q >= srbp_pkg::OQ_CNT_W'(srbp_pkg::OQ_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_nx1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_n == 2'd1) begin
				wr_q <= wr_nx1;
			end else if (push_n == 2'd2) begin
				wr_q <= srbp_pkg::oq_next(wr_nx1);
			end
			if (pop) begin
				rd_q <= srbp_pkg::oq_next(rd_q);
			end
			count_q <= count_q + push_n - {1'b0, pop};
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= srbp_pkg::OQ_CNT_W'(srbp_pkg::OQ_DEPTH))
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (count_q + push_n <= 3'(srbp_pkg::OQ_DEPTH)))
		else $error("result queue overflow");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == 2'd0) |=> (count_q == $past(count_q) - srbp_pkg::OQ_CNT_W'(1)))
		else $error("result queue count lost a pop");

endmodule

`default_nettype wire

[src/sensor_record_bitstream_parser_top.sv]
// Top level of the sensor record bitstream parser.
// Takes one stream byte per transfer, most significant bit first, and splits it into
// records of a length, a time delta, sensor status codes and sensor values. Each
// accepted byte is parsed in the cycle it is taken: eight bit steps run in one
// combinational pass from the parser state register, and its zero, one or two results
// go into a three-entry result queue, so results appear from the next cycle on. A byte
// is taken in every cycle while fewer than two results wait in that queue; byte_stall
// rises when two or more are waiting, so a byte that yields two results can hold off
// the next byte. After an end-of-stream record, bytes are taken and give no
// results until one arrives with stream_start set.
`timescale 1ns / 1ps
`default_nettype none

module sensor_record_bitstream_parser_top #(
	parameter int SENSOR_COUNT = srbp_pkg::SENSOR_COUNT_DEF,
	parameter int VALUE_BITS   = srbp_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_stall,
	input  srbp_pkg::in_t  byte_data,
	output logic           rec_valid,
	input  logic           rec_stall,
	output srbp_pkg::res_t rec_data
);

	srbp_pkg::parse_state_t state_q;
	srbp_pkg::parse_state_t state_nx;
	srbp_pkg::res_t         res0;
	srbp_pkg::res_t         res1;
	logic [1:0]             res_n;
	logic [1:0]             push_n;
	logic                   acc;
	logic                   q_busy;

	assign acc        = byte_valid && !byte_stall;
	assign byte_stall = q_busy;
	assign push_n     = acc ? res_n : 2'd0;

	srbp_parse #(
		.SENSOR_COUNT(SENSOR_COUNT),
		.VALUE_BITS  (VALUE_BITS)
	) u_parse (
		.cur    (state_q),
		.data_in(byte_data),
		.nxt    (state_nx),
		.res0   (res0),
		.res1   (res1),
		.res_n  (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srbp_pkg::PARSE_STATE_RST;
		end else if (acc) begin
			state_q <= state_nx;
		end
	end

	srbp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push0    (res0),
		.push1    (res1),
		.full_ish (q_busy),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec_data (rec_data)
	);

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == srbp_pkg::PH_DONE && !(acc && byte_data.stream_start))
		|=> (state_q.phase == srbp_pkg::PH_DONE))
		else $error("parser left end of stream without a stream start");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && state_q.phase == srbp_pkg::PH_DONE && !byte_data.stream_start)
		|-> (res_n == 2'd0))
		else $error("results produced after end of stream");

	a_zero_len_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && byte_data.stream_start && byte_data.data_byte[7:2] == 6'd0)
		|=> (state_q.phase == srbp_pkg::PH_DONE))
		else $error("zero length after stream start did not end the stream");

	a_time_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(state_q.time_total))
		else $error("accumulated time changed without a byte transfer");

endmodule

`default_nettype wire

[tb/tb_sensor_record_bitstream_parser_top.sv]
// Self-checking testbench for the sensor record bitstream parser top level.
`timescale 1ns / 1ps

module tb_sensor_record_bitstream_parser_top;

	localparam int SENSORS      = srbp_pkg::SENSOR_COUNT_DEF;
	localparam int VBITS        = srbp_pkg::VALUE_BITS_DEF;
	localparam int RESULT_CAP   = 2;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTED  = 40;

	logic           clk;
	logic           arst_n;
	logic           byte_valid;
	logic           byte_stall;
	srbp_pkg::in_t  byte_data;
	logic           rec_valid;
	logic           rec_stall;
	srbp_pkg::res_t rec_data;

	// Parser state as predicted from the accepted bytes.
	srbp_pkg::phase_t             prs_phase = srbp_pkg::PH_LEN;
	int                           prs_nbits = 0;
	logic [srbp_pkg::TIME_W-1:0]  prs_shift = '0;
	int                           prs_delta_len = 0;
	logic [srbp_pkg::TIME_W-1:0]  prs_time = '0;
	int                           prs_left = 0;
	logic [srbp_pkg::INDEX_W-1:0] prs_ordinal = '0;

	srbp_pkg::res_t records_expected[$];
	bit             stream_bits[$];

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int error_count = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	int cycle_count = 0;

	sensor_record_bitstream_parser_top #(
		.SENSOR_COUNT(SENSORS),
		.VALUE_BITS  (VBITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_data  (rec_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		if (error_count < MAX_PRINTED) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want_v);
		if (got !== want_v) begin
			report_error($sformatf("result %0d %s: got %h, expected %h",
				results_checked, name, got, want_v));
		end
	endtask

	// Runs the eight bit steps of one byte and queues the records it completes.
	task automatic parse_byte(input srbp_pkg::in_t item);
		srbp_pkg::res_t found[$];
		srbp_pkg::res_t r;
		bit             hit;
		int             count;
		if (item.stream_start) begin
			prs_phase     = srbp_pkg::PH_LEN;
			prs_nbits     = 0;
			prs_shift     = '0;
			prs_delta_len = 0;
			prs_time      = '0;
			prs_left      = 0;
			prs_ordinal   = '0;
		end
		for (int b = 7; b >= 0 && prs_phase != srbp_pkg::PH_DONE; b--) begin
			prs_shift = {prs_shift[srbp_pkg::TIME_W-2:0], item.data_byte[b]};
			prs_nbits++;
			r   = '0;
			hit = 1'b0;
			case (prs_phase)
				srbp_pkg::PH_LEN: begin
					if (prs_nbits >= srbp_pkg::LEN_BITS) begin
						if (prs_shift[srbp_pkg::LEN_BITS-1:0] == '0) begin
							r.kind    = srbp_pkg::KIND_END;
							hit       = 1'b1;
							prs_phase = srbp_pkg::PH_DONE;
						end else begin
							prs_delta_len = int'(prs_shift[srbp_pkg::LEN_BITS-1:0]);
							prs_phase     = srbp_pkg::PH_DELTA;
						end
						prs_nbits = 0;
						prs_shift = '0;
					end
				end
				srbp_pkg::PH_DELTA: begin
					if (prs_nbits >= prs_delta_len) begin
						prs_time  = prs_time + prs_shift;
						r.kind    = srbp_pkg::KIND_TIME;
						r.value   = prs_time;
						hit       = 1'b1;
						prs_phase = srbp_pkg::PH_STATUS;
						prs_nbits = 0;
						prs_shift = '0;
					end
				end
				srbp_pkg::PH_STATUS: begin
					if (prs_nbits >= srbp_pkg::CODE_BITS * SENSORS) begin
						count = 0;
						for (int s = 0; s < SENSORS; s++) begin
							if (prs_shift[srbp_pkg::CODE_BITS * (SENSORS - 1 - s) +:
									srbp_pkg::CODE_BITS] < 2) begin
								count++;
							end
						end
						r.kind          = srbp_pkg::KIND_STATUS;
						r.status_codes  = prs_shift[srbp_pkg::STATUS_W-1:0];
						r.present_count = srbp_pkg::COUNT_W'(count);
						hit             = 1'b1;
						if (count == 0) begin
							prs_phase = srbp_pkg::PH_LEN;
						end else begin
							prs_left    = count;
							prs_ordinal = '0;
							prs_phase   = srbp_pkg::PH_VALUES;
						end
						prs_nbits = 0;
						prs_shift = '0;
					end
				end
				srbp_pkg::PH_VALUES: begin
					if (prs_nbits >= VBITS) begin
						r.kind        = srbp_pkg::KIND_VALUE;
						r.value       = prs_shift;
						r.value_index = prs_ordinal;
						hit           = 1'b1;
						prs_ordinal++;
						if (prs_left > 0) begin
							prs_left--;
						end
						if (prs_left == 0) begin
							prs_phase = srbp_pkg::PH_LEN;
						end
						prs_nbits = 0;
						prs_shift = '0;
					end
				end
				default: begin
				end
			endcase
			// Completions beyond the second in one byte are dropped.
			if (hit && found.size() < RESULT_CAP) begin
				found.push_back(r);
			end
		end
		if (found.size() > 0) begin
			found[found.size() - 1].last = 1'b1;
		end
		foreach (found[i]) begin
			records_expected.push_back(found[i]);
		end
	endtask

	always @(posedge clk) begin : check_records
		srbp_pkg::res_t want;
		if (arst_n) begin
			if (rec_valid && !rec_stall) begin
				if (records_expected.size() == 0) begin
					report_error($sformatf("record with none expected: kind %0d value %h",
						rec_data.kind, rec_data.value));
				end else begin
					want = records_expected.pop_front();
					check_field("kind", rec_data.kind, want.kind);
					check_field("value", rec_data.value, want.value);
					check_field("status_codes", rec_data.status_codes, want.status_codes);
					check_field("present_count", rec_data.present_count, want.present_count);
					check_field("value_index", rec_data.value_index, want.value_index);
					check_field("last", rec_data.last, want.last);
					results_checked++;
				end
			end
			if (byte_valid && !byte_stall) begin
				parse_byte(byte_data);
			end
		end
	end

	initial begin
		rec_stall = 1'b0;
		forever begin
			@(negedge clk);
			rec_stall <= ($urandom_range(99) < snk_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d records still expected",
			cycle_count, records_expected.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= '{data_byte: b, stream_start: start};
		do @(posedge clk); while (byte_stall);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic push_bits(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			stream_bits.push_back(v[i]);
		end
	endtask

	// Appends one record; vals holds the values of the present sensors, first lowest.
	task automatic queue_record(input int len, input logic [63:0] delta,
			input logic [srbp_pkg::STATUS_W-1:0] codes,
			input logic [SENSORS*VBITS-1:0] vals);
		int k;
		push_bits(64'(len), srbp_pkg::LEN_BITS);
		push_bits(delta, len);
		push_bits(64'(codes), srbp_pkg::STATUS_W);
		k = 0;
		for (int s = 0; s < SENSORS; s++) begin
			if (codes[srbp_pkg::CODE_BITS * (SENSORS - 1 - s) +: srbp_pkg::CODE_BITS] < 2) begin
				push_bits(64'(vals[k * VBITS +: VBITS]), VBITS);
				k++;
			end
		end
	endtask

	// Packs the queued bits into bytes, padding the last one with random bits, then sends pad_bytes random bytes.
	task automatic send_stream(input logic start, input int pad_bytes);
		logic [7:0] b;
		logic       first;
		first = start;
		while (stream_bits.size() > 0) begin
			for (int i = 7; i >= 0; i--) begin
				b[i] = (stream_bits.size() > 0) ? stream_bits.pop_front() : 1'($urandom_range(1));
			end
			send_byte(b, first);
			first = 1'b0;
		end
		repeat (pad_bytes) begin
			send_byte(8'($urandom), 1'b0);
		end
	endtask

	function automatic logic [VBITS-1:0] rand_value();
		logic [VBITS-1:0] v;
		case ($urandom_range(5))
			0: v = '0;
			1: v = '1;
			default: v = VBITS'($urandom);
		endcase
		return v;
	endfunction

	// Three widest deltas of all ones push the accumulated time past 2^64.
	// The stream starts without stream_start, relying on the reset state.
	task automatic test_time_wrap();
		queue_record(63, 64'h7FFF_FFFF_FFFF_FFFF, 10'b11_11_11_11_11, '0);
		queue_record(63, 64'h7FFF_FFFF_FFFF_FFFF, 10'b10_10_10_10_10, '0);
		queue_record(63, 64'h7FFF_FFFF_FFFF_FFFF, 10'b11_10_01_10_11, {16'h0, 16'hFFFF});
		push_bits('0, srbp_pkg::LEN_BITS);
		send_stream(1'b0, 1);
	endtask

	// Shortest delta, then every sensor present with extreme values.
	task automatic test_value_extremes();
		queue_record(1, 64'd1, 10'b00_00_00_00_01,
			{16'h7FFE, 16'h0001, 16'h8000, 16'h0000, 16'hFFFF});
		push_bits('0, srbp_pkg::LEN_BITS);
		send_stream(1'b1, 1);
	endtask

	// A record cut off by a restart, then a short stream whose trailing bytes are ignored.
	task automatic test_end_and_restart();
		push_bits(64'd40, srbp_pkg::LEN_BITS);
		push_bits(64'h3, 10);
		send_stream(1'b1, 0);
		queue_record(2, 64'd3, 10'b11_10_11_10_10, '0);
		push_bits('0, srbp_pkg::LEN_BITS);
		send_stream(1'b1, 2);
	endtask

	task automatic test_random_streams(input int src_pct, input int snk_pct, input int n_bytes);
		int                       goal;
		int                       len;
		logic [63:0]              delta;
		logic [SENSORS*VBITS-1:0] vals;
		src_idle_pct  = src_pct;
		snk_stall_pct = snk_pct;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			if ($urandom_range(9) == 0) begin
				// Noise: any of these bytes may restart the parser mid-record.
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom), 1'($urandom_range(1)));
				end
			end else begin
				repeat ($urandom_range(1, 5)) begin
					len   = ($urandom_range(7) == 0) ? 63 : $urandom_range(1, 63);
					delta = {$urandom, $urandom} & ((64'd1 << len) - 64'd1);
					for (int k = 0; k < SENSORS; k++) begin
						vals[k * VBITS +: VBITS] = rand_value();
					end
					queue_record(len, delta, srbp_pkg::STATUS_W'($urandom), vals);
				end
				// Most streams close with an end record; some break off or lose their tail.
				if ($urandom_range(4) != 0) begin
					push_bits('0, srbp_pkg::LEN_BITS);
				end else if ($urandom_range(1) == 1) begin
					repeat ($urandom_range(1, 20)) begin
						if (stream_bits.size() > 1) begin
							void'(stream_bits.pop_back());
						end
					end
				end
				send_stream(1'b1, $urandom_range(0, 1));
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_time_wrap();
		test_value_extremes();
		test_end_and_restart();
		test_random_streams(0, 0, 125);
		test_random_streams(78, 0, 125);
		test_random_streams(0, 78, 125);
		test_random_streams(6, 6, 125);

		byte_valid <= 1'b0;
		while (records_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Parsed %0d stream bytes into %0d checked records: time wrap, value extremes,",
			bytes_sent, results_checked);
		$display("restarts, noise and truncated streams under four flow-control mixes.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
